### rtl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int unsigned LaDepth = 12;
  localparam int unsigned QDepth  = 16;
  localparam int unsigned OutMax  = 12;

  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast  = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast  = 16'hDFFF;
  localparam logic [20:0] PlaneOne = 21'h10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_COPY,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic take;
    logic end_bsl;
    logic end_fail;
    logic copy;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic pend_empty;
    logic take_fail;
    logic held_one;
    logic held_multi;
    logic final_str;
    logic obuf_empty;
    logic copy_done;
    logic out_last;
  } sts_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } utf8_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.bytes[0] = cp[7:0];
      r.n = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
      r.n = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

endpackage

### rtl/jsu_in_if.sv
`timescale 1ns / 1ps
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink (input valid, input in_byte, input string_last, output ready);
endinterface

### rtl/jsu_out_if.sv
`timescale 1ns / 1ps
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

### rtl/jsu_datapath.sv
`timescale 1ns / 1ps
module jsu_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jsu_pkg::cmd_t cmd_i,
  input  logic [7:0]    in_byte_i,
  input  logic          string_last_i,
  output jsu_pkg::sts_t sts_o,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          string_end_o
);

  logic [7:0] la_q [jsu_pkg::LaDepth];
  logic [7:0] q_q  [jsu_pkg::QDepth];
  logic [7:0] ob_q [jsu_pkg::OutMax];

  logic [3:0]      held_q, held_d;
  logic [15:0]     hi_q, hi_d, lo_q, lo_d;
  logic [3:0]      head_q, head_d;
  logic [4:0]      len_q, len_d;
  logic [3:0][7:0] pend_q, pend_d;
  logic [2:0]      pcnt_q, pcnt_d;
  logic [3:0]      ocnt_q, ocnt_d, ord_q, ord_d;
  logic            final_q, final_d;
  logic [3:0]      cpk_q, cpk_d, cpdst_q, cpdst_d;

  // Take decode of the byte at the queue head.
  logic [7:0]      b, first;
  logic [3:0]      hb, n;
  logic [4:0]      dig;
  logic [15:0]     hi_new, lo_new;
  logic            t_fail;
  logic [3:0]      t_held;
  logic [3:0][7:0] t_pb;
  logic [2:0]      t_pn;
  jsu_pkg::utf8_t  u8;
  logic [20:0]     cp;

  always_comb begin
    b      = q_q[head_q];
    hb     = (held_q >= 4'(jsu_pkg::LaDepth)) ? 4'd0 : held_q;
    n      = hb + 4'd1;
    first  = (hb == 4'd0) ? b : la_q[0];
    dig    = jsu_pkg::hex_val(b);
    hi_new = {hi_q[11:0], dig[3:0]};
    lo_new = {lo_q[11:0], dig[3:0]};
    t_fail = 1'b0;
    t_held = 4'd0;
    t_pb   = '0;
    t_pn   = 3'd0;
    cp     = '0;
    u8     = '0;
    if (first != jsu_pkg::ChBsl) begin
      t_pb[0] = b;
      t_pn    = 3'd1;
    end else if (n == 4'd1) begin
      t_held = 4'd1;
    end else if (n == 4'd2) begin
      t_pn = 3'd1;
      case (b)
        jsu_pkg::ChN:     t_pb[0] = 8'h0A;
        jsu_pkg::ChR:     t_pb[0] = 8'h0D;
        jsu_pkg::ChT:     t_pb[0] = 8'h09;
        jsu_pkg::ChB:     t_pb[0] = 8'h08;
        jsu_pkg::ChF:     t_pb[0] = 8'h0C;
        jsu_pkg::ChQuote: t_pb[0] = jsu_pkg::ChQuote;
        jsu_pkg::ChSlash: t_pb[0] = jsu_pkg::ChSlash;
        jsu_pkg::ChBsl:   t_pb[0] = jsu_pkg::ChBsl;
        jsu_pkg::ChU: begin
          t_pn   = 3'd0;
          t_held = 4'd2;
        end
        default: begin
          // Unknown escape passes through as it came.
          t_pb[0] = jsu_pkg::ChBsl;
          t_pb[1] = b;
          t_pn    = 3'd2;
        end
      endcase
    end else if (n <= 4'd6) begin
      if (!dig[4]) begin
        t_fail = 1'b1;
      end else if (n < 4'd6) begin
        t_held = n;
      end else if (hi_new >= jsu_pkg::LoFirst && hi_new <= jsu_pkg::LoLast) begin
        t_fail = 1'b1;
      end else if (hi_new >= jsu_pkg::HiFirst && hi_new <= jsu_pkg::HiLast) begin
        t_held = n;
      end else begin
        cp   = {5'b0, hi_new};
        u8   = jsu_pkg::utf8_enc(cp);
        t_pb = u8.bytes;
        t_pn = u8.n;
      end
    end else if (n == 4'd7) begin
      t_fail = (b != jsu_pkg::ChBsl);
      t_held = n;
    end else if (n == 4'd8) begin
      t_fail = (b != jsu_pkg::ChU);
      t_held = n;
    end else begin
      if (!dig[4]) begin
        t_fail = 1'b1;
      end else if (n < 4'd12) begin
        t_held = n;
      end else if (!(lo_new >= jsu_pkg::LoFirst && lo_new <= jsu_pkg::LoLast)) begin
        t_fail = 1'b1;
      end else begin
        cp   = {1'b0, hi_q[9:0], lo_new[9:0]} + jsu_pkg::PlaneOne;
        u8   = jsu_pkg::utf8_enc(cp);
        t_pb = u8.bytes;
        t_pn = u8.n;
      end
    end
    if (t_fail) begin
      t_held  = n;
      t_pb    = '0;
      t_pb[0] = jsu_pkg::ChBsl;
      t_pb[1] = jsu_pkg::ChU;
      t_pn    = 3'd2;
    end
  end

  logic       fail_any;
  logic [3:0] head_base, nf, back;
  logic [4:0] len_base;
  logic       cp_we;
  logic       la_we;
  logic       ob_we;

  always_comb begin
    held_d  = held_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    head_d  = head_q;
    len_d   = len_q;
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    ocnt_d  = ocnt_q;
    ord_d   = ord_q;
    final_d = final_q;
    cpk_d   = cpk_q;
    cpdst_d = cpdst_q;
    cp_we   = 1'b0;
    la_we   = 1'b0;
    ob_we   = 1'b0;

    fail_any  = (cmd_i.take && t_fail) || cmd_i.end_fail;
    head_base = cmd_i.take ? head_q + 4'd1 : head_q;
    len_base  = cmd_i.take ? len_q - 5'd1 : len_q;
    nf        = cmd_i.take ? n : held_q;
    back      = nf - 4'd2;

    // Pending bytes move into the result buffer one per cycle.
    if (pcnt_q != 3'd0) begin
      ob_we  = (ocnt_q < 4'(jsu_pkg::OutMax));
      ocnt_d = ob_we ? ocnt_q + 4'd1 : ocnt_q;
      pend_d = {8'h00, pend_q[3:1]};
      pcnt_d = pcnt_q - 3'd1;
    end

    if (cmd_i.accept) begin
      head_d  = '0;
      len_d   = 5'd1;
      final_d = string_last_i;
      ocnt_d  = '0;
      ord_d   = '0;
    end

    if (cmd_i.take) begin
      la_we  = 1'b1;
      head_d = head_base;
      len_d  = len_base;
      held_d = t_held;
      pend_d = t_pb;
      pcnt_d = t_pn;
      if (n >= 4'd3 && n <= 4'd6) begin
        hi_d = hi_new;
      end
      if (n >= 4'd9) begin
        lo_d = lo_new;
      end
    end

    if (cmd_i.end_bsl) begin
      pend_d    = '0;
      pend_d[0] = jsu_pkg::ChBsl;
      pcnt_d    = 3'd1;
      held_d    = '0;
    end

    if (cmd_i.end_fail) begin
      pend_d    = '0;
      pend_d[0] = jsu_pkg::ChBsl;
      pend_d[1] = jsu_pkg::ChU;
      pcnt_d    = 3'd2;
    end

    // A failed escape puts the held bytes from the first hex digit on back
    // in front of the queue.
    if (fail_any) begin
      held_d  = nf;
      head_d  = head_base - back;
      len_d   = len_base + 5'(back);
      cpk_d   = 4'd2;
      cpdst_d = head_base - back;
    end

    if (cmd_i.copy) begin
      if (cpk_q == held_q) begin
        held_d = '0;
      end else begin
        cp_we   = 1'b1;
        cpk_d   = cpk_q + 4'd1;
        cpdst_d = cpdst_q + 4'd1;
      end
    end

    if (cmd_i.pop) begin
      ord_d = ord_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      head_q  <= '0;
      len_q   <= '0;
      pcnt_q  <= '0;
      ocnt_q  <= '0;
      ord_q   <= '0;
      final_q <= 1'b0;
      cpk_q   <= '0;
      cpdst_q <= '0;
    end else begin
      held_q  <= held_d;
      head_q  <= head_d;
      len_q   <= len_d;
      pcnt_q  <= pcnt_d;
      ocnt_q  <= ocnt_d;
      ord_q   <= ord_d;
      final_q <= final_d;
      cpk_q   <= cpk_d;
      cpdst_q <= cpdst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    pend_q <= pend_d;
    if (la_we) begin
      la_q[hb] <= b;
    end
    if (cmd_i.accept) begin
      q_q[0] <= in_byte_i;
    end else if (cp_we) begin
      q_q[cpdst_q] <= la_q[cpk_q];
    end
    if (ob_we) begin
      ob_q[ocnt_q] <= pend_q[0];
    end
  end

  always_comb begin
    sts_o.queue_empty = (len_q == 5'd0);
    sts_o.pend_empty  = (pcnt_q == 3'd0);
    sts_o.take_fail   = t_fail;
    sts_o.held_one    = (held_q == 4'd1);
    sts_o.held_multi  = (held_q >= 4'd2);
    sts_o.final_str   = final_q;
    sts_o.obuf_empty  = (ocnt_q == 4'd0);
    sts_o.copy_done   = (cpk_q == held_q);
    sts_o.out_last    = (ord_q == ocnt_q - 4'd1);
  end

  assign out_byte_o   = ob_q[ord_q];
  assign run_last_o   = sts_o.out_last;
  assign string_end_o = sts_o.out_last && final_q;

endmodule

### rtl/jsu_ctrl.sv
`timescale 1ns / 1ps
module jsu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  jsu_pkg::sts_t sts_i,
  output jsu_pkg::cmd_t cmd_o
);

  jsu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      jsu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = jsu_pkg::S_RUN;
        end
      end
      jsu_pkg::S_RUN: begin
        if (!sts_i.pend_empty) begin
          state_d = jsu_pkg::S_RUN;
        end else if (!sts_i.queue_empty) begin
          if (sts_i.take_fail) begin
            state_d = jsu_pkg::S_COPY;
          end
        end else if (sts_i.final_str && sts_i.held_multi) begin
          state_d = jsu_pkg::S_COPY;
        end else if (sts_i.final_str && sts_i.held_one) begin
          state_d = jsu_pkg::S_RUN;
        end else if (sts_i.obuf_empty) begin
          state_d = jsu_pkg::S_IDLE;
        end else begin
          state_d = jsu_pkg::S_DRAIN;
        end
      end
      jsu_pkg::S_COPY: begin
        if (sts_i.copy_done) begin
          state_d = jsu_pkg::S_RUN;
        end
      end
      jsu_pkg::S_DRAIN: begin
        if (out_ready_i && sts_i.out_last) begin
          state_d = jsu_pkg::S_IDLE;
        end
      end
      default: state_d = jsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      jsu_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      jsu_pkg::S_RUN: begin
        if (sts_i.pend_empty) begin
          if (!sts_i.queue_empty) begin
            cmd_o.take = 1'b1;
          end else if (sts_i.final_str && sts_i.held_multi) begin
            cmd_o.end_fail = 1'b1;
          end else if (sts_i.final_str && sts_i.held_one) begin
            cmd_o.end_bsl = 1'b1;
          end
        end
      end
      jsu_pkg::S_COPY: begin
        cmd_o.copy = 1'b1;
      end
      jsu_pkg::S_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// JSON string unescaper with UTF-8 output.
// in_i carries one source byte per transfer with string_last on the final
// byte of a string. out_o carries the decoded bytes; run_last marks the last
// byte caused by one input transfer and string_end the final byte of a string.
// An input byte that resolves nothing produces no output transfer.
// One input byte is worked on at a time. After the input transfer the engine
// takes bytes from its replay queue one at a time and writes each decoded
// byte to its result buffer. A failed unicode escape puts its held bytes from
// the first hex digit on back into the queue, and at the end of a string any
// bytes still held are resolved as well. The buffered bytes are then offered
// one per cycle while the receiver is ready.
// Output bytes are held stable while the receiver stalls, and no new input
// is taken until every byte of the current one has been transferred.
// Reset empties the escape state and the queues; held lookahead bytes keep
// no reset value and are always written before use.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  jsu_pkg::cmd_t cmd;
  jsu_pkg::sts_t sts;

  jsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jsu_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_byte_i     (in_i.in_byte),
    .string_last_i (in_i.string_last),
    .sts_o         (sts),
    .out_byte_o    (out_o.out_byte),
    .run_last_o    (out_o.run_last),
    .string_end_o  (out_o.string_end)
  );

endmodule

### rtl/jsu_checker.sv
`timescale 1ns / 1ps
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       string_end_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(run_last_i))
    else $error("output changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second input taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && run_last_i |=> !out_valid_i)
    else $error("output continued after the last byte of a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_last_i)
    else $error("string end without run end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while results are pending");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .run_last_i   (out_o.run_last),
  .string_end_i (out_o.string_end)
);

### verif/json_string_unescape_utf8_chk.sv
`timescale 1ns / 1ps
module json_string_unescape_utf8_chk (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic in_last_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic out_run_last_i,
  input  logic out_str_end_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } dec_byte_t;

  dec_byte_t decoded_q[$];

  logic [7:0] hold_mem[jsu_pkg::LaDepth];
  int unsigned hold_cnt;
  logic [7:0] replay_q[$];
  logic [7:0] step_bytes[$];

  function automatic logic [4:0] hexv(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [15:0] quad(input int pos);
    logic [15:0] v;
    logic [4:0]  d;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      d = hexv(hold_mem[(pos + k) % jsu_pkg::LaDepth]);
      v = {v[11:0], d[3:0]};
    end
    return v;
  endfunction

  task automatic put(input logic [7:0] b);
    if (step_bytes.size() < jsu_pkg::OutMax) step_bytes.push_back(b);
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      put(8'hC0 | {3'b0, cp[10:6]});
      put(8'h80 | {2'b0, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      put(8'hE0 | {4'b0, cp[15:12]});
      put(8'h80 | {2'b0, cp[11:6]});
      put(8'h80 | {2'b0, cp[5:0]});
    end else if (cp <= 21'h10FFFF) begin
      put(8'hF0 | {5'b0, cp[20:18]});
      put(8'h80 | {2'b0, cp[17:12]});
      put(8'h80 | {2'b0, cp[11:6]});
      put(8'h80 | {2'b0, cp[5:0]});
    end
  endtask

  // The held bytes after backslash-u go back in front of the replay queue.
  task automatic abandon_escape();
    logic [7:0] tmp[$];
    put(jsu_pkg::ChBsl);
    put(jsu_pkg::ChU);
    for (int k = 2; k < hold_cnt; k++) tmp.push_back(hold_mem[k]);
    foreach (replay_q[k]) tmp.push_back(replay_q[k]);
    while (tmp.size() > jsu_pkg::QDepth) void'(tmp.pop_back());
    replay_q = tmp;
    hold_cnt = 0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned n;
    logic [15:0] hi, lo;
    logic [4:0]  d;
    d = hexv(b);
    if (hold_cnt >= jsu_pkg::LaDepth) hold_cnt = 0;
    hold_mem[hold_cnt] = b;
    hold_cnt++;
    n = hold_cnt;
    if (hold_mem[0] != jsu_pkg::ChBsl) begin
      put(b);
      hold_cnt = 0;
    end else if (n == 2) begin
      hold_cnt = 0;
      case (b)
        jsu_pkg::ChN: put(8'h0A);
        jsu_pkg::ChR: put(8'h0D);
        jsu_pkg::ChT: put(8'h09);
        jsu_pkg::ChB: put(8'h08);
        jsu_pkg::ChF: put(8'h0C);
        jsu_pkg::ChQuote, jsu_pkg::ChSlash, jsu_pkg::ChBsl: put(b);
        jsu_pkg::ChU: hold_cnt = 2;
        default: begin
          put(jsu_pkg::ChBsl);
          put(b);
        end
      endcase
    end else if (n >= 3 && n <= 6) begin
      if (!d[4]) begin
        abandon_escape();
      end else if (n == 6) begin
        hi = quad(2);
        if (hi >= jsu_pkg::LoFirst && hi <= jsu_pkg::LoLast) abandon_escape();
        else if (!(hi >= jsu_pkg::HiFirst && hi <= jsu_pkg::HiLast)) begin
          put_utf8({5'd0, hi});
          hold_cnt = 0;
        end
      end
    end else if (n == 7) begin
      if (b != jsu_pkg::ChBsl) abandon_escape();
    end else if (n == 8) begin
      if (b != jsu_pkg::ChU) abandon_escape();
    end else if (n > 8) begin
      if (!d[4]) begin
        abandon_escape();
      end else if (n == 12) begin
        hi = quad(2);
        lo = quad(8);
        if (!(lo >= jsu_pkg::LoFirst && lo <= jsu_pkg::LoLast)) abandon_escape();
        else begin
          put_utf8(jsu_pkg::PlaneOne + ({5'd0, hi - jsu_pkg::HiFirst} << 10) +
                   {5'd0, lo - jsu_pkg::LoFirst});
          hold_cnt = 0;
        end
      end
    end
  endtask

  task automatic predict(input logic [7:0] b, input logic fin);
    dec_byte_t e;
    step_bytes = {};
    replay_q = {b};
    forever begin
      while (replay_q.size() > 0) decode_byte(replay_q.pop_front());
      if (!fin || hold_cnt == 0) break;
      if (hold_cnt == 1) begin
        put(jsu_pkg::ChBsl);
        hold_cnt = 0;
        break;
      end
      abandon_escape();
    end
    foreach (step_bytes[k]) begin
      e.data = step_bytes[k];
      e.run_last = (k == step_bytes.size() - 1);
      e.str_end = e.run_last && fin;
      decoded_q.push_back(e);
    end
  endtask

  int unsigned fails;
  int unsigned pend_n;
  assign fail_cnt_o = fails;
  assign pending_o = pend_n;

  always @(posedge clk_i or negedge rst_ni) begin
    dec_byte_t e;
    if (!rst_ni) begin
      fails = 0;
      hold_cnt = 0;
      decoded_q = {};
      pend_n = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Unexpected output byte %h", out_byte_i);
        end else begin
          e = decoded_q.pop_front();
          if (e != {out_byte_i, out_run_last_i, out_str_end_i}) begin
            fails++;
            if (fails <= 10)
              $display("Output mismatch: expected %h/%b/%b, got %h/%b/%b", e.data,
                       e.run_last, e.str_end, out_byte_i, out_run_last_i, out_str_end_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict(in_byte_i, in_last_i);
      pend_n = decoded_q.size();
    end
  end

endmodule

### verif/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  jsu_in_if  in_if ();
  jsu_out_if out_if ();
  int unsigned fail_cnt, pending;
  int unsigned quiet_cycles = 0;
  logic bursty;

  json_string_unescape_utf8 i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  json_string_unescape_utf8_chk i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_byte_i     (in_if.in_byte),
    .in_last_i     (in_if.string_last),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_byte_i    (out_if.out_byte),
    .out_run_last_i(out_if.run_last),
    .out_str_end_i (out_if.string_end),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    if (bursty) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(0, 2);
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.string_last = 1'b0;
    out_if.ready = 1'b0;
    bursty = 1'b0;
  end

  // Receiver stalls.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      g = gap_len();
      if (g > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Ready only changes at the rising edge, so its value at the falling edge
  // tells whether the next rising edge completes the transfer.
  task automatic send(input logic [7:0] b, input logic fin);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.string_last <= fin;
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_str(input string s, input logic fin);
    for (int k = 0; k < s.len(); k++) send(s[k], fin && (k == s.len() - 1));
  endtask

  function automatic logic [7:0] hex_ch(input logic [3:0] v);
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : base + {4'd0, v} - 8'd10;
  endfunction

  task automatic send_uesc(input logic [15:0] v);
    send(jsu_pkg::ChBsl, 1'b0);
    send(jsu_pkg::ChU, 1'b0);
    for (int k = 3; k >= 0; k--) send(hex_ch(v[k*4+:4]), 1'b0);
  endtask

  function automatic logic [7:0] rnd_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 255));
      1: return jsu_pkg::ChBsl;
      2: return jsu_pkg::ChU;
      3: return hex_ch(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  initial begin
    logic [7:0] esc[8] = '{jsu_pkg::ChN, jsu_pkg::ChR, jsu_pkg::ChT, jsu_pkg::ChB,
                           jsu_pkg::ChF, jsu_pkg::ChQuote, jsu_pkg::ChSlash, jsu_pkg::ChBsl};
    int unsigned sent;
    int unsigned limit;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send_str("\\n\\r\\t\\b\\f\\\"\\/\\\\\\q", 1'b1);
    send_uesc(16'h0041);
    send_uesc(16'hD83D);
    send_uesc(16'hDE00);
    send_uesc(16'hDC00);
    send_str("\\u12G", 1'b0);
    send_uesc(16'hDBFF);
    send_str("x", 1'b0);
    send_str("\\u00", 1'b1);
    send_str("\\", 1'b1);
    sent = 0;
    while (sent < 240) begin
      bursty = ($urandom_range(0, 7) == 0);
      limit = $urandom_range(1, 14);
      case ($urandom_range(0, 5))
        0: begin
          send(jsu_pkg::ChBsl, 1'b0);
          send(esc[3'($urandom_range(0, 7))], 1'b0);
          sent += 2;
        end
        1: begin
          send_uesc(16'($urandom_range(0, 16'hFFFF)));
          sent += 6;
        end
        2: begin
          send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
          send_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
          sent += 12;
        end
        default: begin
          for (int k = 0; k < limit; k++) send(rnd_char(), 1'b0);
          sent += limit;
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        send(rnd_char(), 1'b1);
        sent++;
      end
    end
    send_str("\\ud800", 1'b1);
    in_if.valid <= 1'b0;
    bursty = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
